@@ rtl/core/pps_pkg.sv @@
// pll parameter search: shared widths, register indexes and types
// no dependencies; used by the channel interfaces and every module
`timescale 1ns / 1ps

package pps_pkg;

    localparam int unsigned REF_W      = 18;
    localparam int unsigned VCO_KHZ_W  = 21;
    localparam int unsigned MUL_W      = 10;
    localparam int unsigned DIV_W      = 10;
    localparam int unsigned SHIFT_W    = 3;
    localparam int unsigned TARGET_W   = 32;
    localparam int unsigned CLOCK_W    = 41;
    localparam int unsigned REFHZ_W    = 28;  // ref_khz * 1000
    localparam int unsigned VCO_LIM_W  = 31;  // vco limit in hz
    localparam int unsigned VCO_W      = 38;  // ref_hz * mul
    localparam int unsigned ERR_W      = 38;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 21;

    localparam int unsigned KHZ_TO_HZ = 1000;
    localparam int unsigned SHIFT_LOW = 0;

    localparam logic [REF_W-1:0]     RST_REF_KHZ    = REF_W'(14318);
    localparam logic [VCO_KHZ_W-1:0] RST_VCO_MIN    = VCO_KHZ_W'(0);
    localparam logic [VCO_KHZ_W-1:0] RST_VCO_MAX    = VCO_KHZ_W'(2097151);
    localparam logic [MUL_W-1:0]     RST_MUL_LOW    = MUL_W'(1);
    localparam logic [MUL_W-1:0]     RST_MUL_HIGH   = MUL_W'(255);
    localparam logic [DIV_W-1:0]     RST_DIV_LOW    = DIV_W'(1);
    localparam logic [DIV_W-1:0]     RST_DIV_HIGH   = DIV_W'(63);
    localparam logic [SHIFT_W-1:0]   RST_SHIFT_HIGH = SHIFT_W'(3);

    localparam logic [CFG_IDX_W-1:0] REG_REF_KHZ    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_VCO_MIN    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_VCO_MAX    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MUL_LOW    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_MUL_HIGH   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_DIV_LOW    = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_DIV_HIGH   = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_HIGH = CFG_IDX_W'(7);

    typedef struct packed {
        logic [REF_W-1:0]     ref_khz;
        logic [VCO_KHZ_W-1:0] vco_min_khz;
        logic [VCO_KHZ_W-1:0] vco_max_khz;
        logic [MUL_W-1:0]     mul_low;
        logic [MUL_W-1:0]     mul_high;
        logic [DIV_W-1:0]     div_low;
        logic [DIV_W-1:0]     div_high;
        logic [SHIFT_W-1:0]   shift_high;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [VCO_W-1:0] numer;
        logic [DIV_W-1:0] denom;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [VCO_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic               found;
        logic [MUL_W-1:0]   sel_mul;
        logic [DIV_W-1:0]   sel_div;
        logic [SHIFT_W-1:0] best_shift;
        logic [CLOCK_W-1:0] best_clock_hz;
    } t_result;

endpackage

@@ rtl/core/pps_channels.sv @@
// pll parameter search: valid/ready channel interfaces for request and result words
// depends on pps_pkg
`timescale 1ns / 1ps

interface pps_in_if import pps_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [TARGET_W-1:0] target_hz;

    modport source (output valid, output target_hz, input ready);
    modport sink   (input valid, input target_hz, output ready);
endinterface

interface pps_out_if import pps_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               found;
    logic [MUL_W-1:0]   sel_mul;
    logic [DIV_W-1:0]   sel_div;
    logic [SHIFT_W-1:0] best_shift;
    logic [CLOCK_W-1:0] best_clock_hz;

    modport source (output valid, output found, output sel_mul, output sel_div,
                    output best_shift, output best_clock_hz, input ready);
    modport sink   (input valid, input found, input sel_mul, input sel_div,
                    input best_shift, input best_clock_hz, output ready);
endinterface

@@ rtl/core/pps_serial_div.sv @@
// pll parameter search: bit-serial restoring divider, one quotient bit per cycle
// depends on pps_pkg
`timescale 1ns / 1ps

module pps_serial_div import pps_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int unsigned CNT_W = $clog2(VCO_W + 1);

    logic [VCO_W-1:0] r_num;   // numerator bits shift out, quotient bits shift in
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DIV_W:0]   w_trial;
    logic             w_sub;
    logic [DIV_W:0]   w_diff;

    assign w_trial = {r_rem, r_num[VCO_W-1]};
    assign w_sub   = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(VCO_W);
                r_num  <= i_req.numer;
                r_den  <= i_req.denom;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= w_sub ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
                r_num <= {r_num[VCO_W-2:0], w_sub};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;
    assign o_rsp.rem  = r_rem;

endmodule

@@ rtl/core/pps_search.sv @@
// pll parameter search: divider/shift/multiplier sequencer, candidate pipeline, best keeper
// depends on pps_pkg and pps_serial_div
`timescale 1ns / 1ps

module pps_search import pps_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_start,
    input  logic [TARGET_W-1:0] i_target,
    output logic                o_ready,
    output logic                o_res_valid,
    input  logic                i_res_take,
    output t_result             o_res
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DIVCHK = 7'b0000010,
        ST_QDIV   = 7'b0000100,
        ST_SDIV   = 7'b0001000,
        ST_SCAN   = 7'b0010000,
        ST_DRAIN  = 7'b0100000,
        ST_DONE   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [TARGET_W-1:0]  r_target;
    logic [REFHZ_W-1:0]   r_ref_hz;
    logic [VCO_LIM_W-1:0] r_lo;
    logic [VCO_LIM_W-1:0] r_hi;
    logic [DIV_W:0]       r_d;
    logic [SHIFT_W-1:0]   r_s;
    logic [MUL_W-1:0]     r_m;
    logic [VCO_W-1:0]     r_q;
    logic [DIV_W-1:0]     r_r;
    logic [REFHZ_W-1:0]   r_qa;     // ref_hz / d, added per multiplier step
    logic [DIV_W-1:0]     r_ra;
    logic [VCO_W-1:0]     r_q0;     // vco at mul_low
    logic [DIV_W-1:0]     r_r0;

    logic                 r_p1_v;
    logic [MUL_W-1:0]     r_p1_m;
    logic [DIV_W-1:0]     r_p1_d;
    logic [SHIFT_W-1:0]   r_p1_s;
    logic [VCO_W-1:0]     r_p1_clk;
    logic                 r_p2_v;
    logic [MUL_W-1:0]     r_p2_m;
    logic [DIV_W-1:0]     r_p2_d;
    logic [SHIFT_W-1:0]   r_p2_s;
    logic [VCO_W-1:0]     r_p2_clk;
    logic [ERR_W-1:0]     r_p2_err;

    logic                 r_found;
    logic [MUL_W-1:0]     r_sel_mul;
    logic [DIV_W-1:0]     r_sel_div;
    logic [SHIFT_W-1:0]   r_best_shift;
    logic [VCO_W-1:0]     r_best_clk;
    logic [ERR_W-1:0]     r_best_err;

    t_div_req w_req;
    t_div_rsp w_rsp;

    logic [DIV_W:0]   w_rsum;
    logic             w_wrap;
    logic [DIV_W:0]   w_rdiff;
    logic [DIV_W-1:0] w_rnext;
    logic [VCO_W-1:0] w_qnext;
    logic             w_keep;
    logic             w_empty;
    logic             w_last_m;
    logic             w_last_s;
    logic [VCO_W-1:0] w_tgt;

    pps_serial_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // next vco from the current one: add ref_hz/d and carry the remainder
    assign w_rsum  = {1'b0, r_r} + {1'b0, r_ra};
    assign w_wrap  = (w_rsum >= {1'b0, r_d[DIV_W-1:0]});
    assign w_rdiff = w_rsum - {1'b0, r_d[DIV_W-1:0]};
    assign w_rnext = w_wrap ? w_rdiff[DIV_W-1:0] : w_rsum[DIV_W-1:0];
    assign w_qnext = r_q + VCO_W'(r_qa) + VCO_W'(w_wrap);

    // lower vco bound is waived at the largest shift
    assign w_keep = !((r_q < VCO_W'(r_lo)) && (r_s != i_cfg.shift_high))
                    && !(r_q > VCO_W'(r_hi));

    assign w_empty  = (i_cfg.div_low > i_cfg.div_high) || (i_cfg.mul_low > i_cfg.mul_high)
                      || (SHIFT_W'(SHIFT_LOW) > i_cfg.shift_high);
    assign w_last_m = (r_m == i_cfg.mul_high);
    assign w_last_s = (r_s == i_cfg.shift_high);
    assign w_tgt    = VCO_W'(r_target);

    always_comb begin
        w_req.start = 1'b0;
        w_req.numer = VCO_W'(r_ref_hz);
        w_req.denom = r_d[DIV_W-1:0];
        if ((r_state == ST_DIVCHK) && (r_d <= {1'b0, i_cfg.div_high}) && (r_d != '0)) begin
            w_req.start = 1'b1;
        end else if ((r_state == ST_QDIV) && w_rsp.done) begin
            w_req.start = 1'b1;
            w_req.numer = VCO_W'(r_ref_hz) * VCO_W'(i_cfg.mul_low);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = w_empty ? ST_DONE : ST_DIVCHK;
            end
            ST_DIVCHK: begin
                if (r_d > {1'b0, i_cfg.div_high}) n_state = ST_DRAIN;
                else if (r_d != '0)               n_state = ST_QDIV;
            end
            ST_QDIV: begin
                if (w_rsp.done) n_state = ST_SDIV;
            end
            ST_SDIV: begin
                if (w_rsp.done) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (w_last_m && w_last_s) n_state = ST_DIVCHK;
            end
            ST_DRAIN: begin
                if (!r_p1_v && !r_p2_v) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_take) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p1_v  <= (r_state == ST_SCAN) && w_keep;
            r_p2_v  <= r_p1_v;
            if ((r_state == ST_IDLE) && i_start) begin
                r_found <= 1'b0;
            end else if (r_p2_v && (!r_found || (r_p2_err < r_best_err))) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    r_target     <= i_target;
                    r_ref_hz     <= REFHZ_W'(i_cfg.ref_khz * KHZ_TO_HZ);
                    r_lo         <= VCO_LIM_W'(i_cfg.vco_min_khz * KHZ_TO_HZ);
                    r_hi         <= VCO_LIM_W'(i_cfg.vco_max_khz * KHZ_TO_HZ);
                    r_d          <= {1'b0, i_cfg.div_low};
                    r_sel_mul    <= '0;
                    r_sel_div    <= '0;
                    r_best_shift <= '0;
                    r_best_clk   <= '0;
                    r_best_err   <= '0;
                end
            end
            ST_DIVCHK: begin
                // divider zero forms no candidate
                if ((r_d == '0) && (r_d <= {1'b0, i_cfg.div_high})) r_d <= r_d + 1'b1;
            end
            ST_QDIV: begin
                if (w_rsp.done) begin
                    r_qa <= w_rsp.quot[REFHZ_W-1:0];
                    r_ra <= w_rsp.rem;
                end
            end
            ST_SDIV: begin
                if (w_rsp.done) begin
                    r_q0 <= w_rsp.quot;
                    r_r0 <= w_rsp.rem;
                    r_q  <= w_rsp.quot;
                    r_r  <= w_rsp.rem;
                    r_m  <= i_cfg.mul_low;
                    r_s  <= SHIFT_W'(SHIFT_LOW);
                end
            end
            ST_SCAN: begin
                if (w_last_m) begin
                    r_q <= r_q0;
                    r_r <= r_r0;
                    r_m <= i_cfg.mul_low;
                    r_s <= r_s + 1'b1;
                    if (w_last_s) r_d <= r_d + 1'b1;
                end else begin
                    r_q <= w_qnext;
                    r_r <= w_rnext;
                    r_m <= r_m + 1'b1;
                end
            end
            ST_DRAIN, ST_DONE: begin
            end
            default: begin
            end
        endcase

        r_p1_m   <= r_m;
        r_p1_d   <= r_d[DIV_W-1:0];
        r_p1_s   <= r_s;
        r_p1_clk <= r_q >> r_s;

        r_p2_m   <= r_p1_m;
        r_p2_d   <= r_p1_d;
        r_p2_s   <= r_p1_s;
        r_p2_clk <= r_p1_clk;
        r_p2_err <= (r_p1_clk >= w_tgt) ? (r_p1_clk - w_tgt) : (w_tgt - r_p1_clk);

        // strict compare keeps the first candidate on a tie
        if (r_p2_v && (!r_found || (r_p2_err < r_best_err))) begin
            r_sel_mul    <= r_p2_m;
            r_sel_div    <= r_p2_d;
            r_best_shift <= r_p2_s;
            r_best_clk   <= r_p2_clk;
            r_best_err   <= r_p2_err;
        end
    end

    assign o_ready             = (r_state == ST_IDLE);
    assign o_res_valid         = (r_state == ST_DONE);
    assign o_res.found         = r_found;
    assign o_res.sel_mul       = r_sel_mul;
    assign o_res.sel_div       = r_sel_div;
    assign o_res.best_shift    = r_best_shift;
    assign o_res.best_clock_hz = CLOCK_W'(r_best_clk);

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_r < r_d[DIV_W-1:0]))
        else $error("step remainder not below divider");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> (w_req.denom != '0))
        else $error("division started with zero divider");

    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (!r_p1_v && !r_p2_v))
        else $error("result offered with candidates in flight");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && !r_found) |->
            ((r_sel_mul == '0) && (r_sel_div == '0) && (r_best_clk == '0)))
        else $error("nonzero fields without a found candidate");

endmodule

@@ rtl/core/pll_parameter_search_core.sv @@
// pll parameter search top level: config registers, request channel, result register
// depends on pps_pkg, pps_channels, pps_search
`timescale 1ns / 1ps
//
// Usage:
//   i_in carries one word per request, the target clock in hz; o_out returns one
//   word per request: found flag, multiplier, divider, shift and resulting clock.
//   Both are valid/ready channels; a word moves when valid and ready are high.
//   Config registers are written through i_cfg_we/i_cfg_idx/i_cfg_data while the
//   block is idle; register index i is the i-th register, data is masked to width.
// Search:
//   per divider in range: two 38-bit bit-serial divisions, then one candidate step
//   for every (shift, multiplier) pair; each request also has setup and a pipeline
//   drain. The divider and the single candidate stepper set the search time.
// Reset:
//   synchronous active low; registers return to their reset values, no request
//   is pending and o_out is empty.
// Stall:
//   a finished result sits in the output register; a new request is accepted at
//   once, and its result is held in the search unit until o_out is taken.

module pll_parameter_search_core import pps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pps_in_if.sink                i_in,
    pps_out_if.source             o_out
);

    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_out;

    logic    w_ready;
    logic    w_res_valid;
    logic    w_load;
    t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_khz     <= RST_REF_KHZ;
            r_cfg.vco_min_khz <= RST_VCO_MIN;
            r_cfg.vco_max_khz <= RST_VCO_MAX;
            r_cfg.mul_low     <= RST_MUL_LOW;
            r_cfg.mul_high    <= RST_MUL_HIGH;
            r_cfg.div_low     <= RST_DIV_LOW;
            r_cfg.div_high    <= RST_DIV_HIGH;
            r_cfg.shift_high  <= RST_SHIFT_HIGH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_REF_KHZ:    r_cfg.ref_khz     <= i_cfg_data[REF_W-1:0];
                REG_VCO_MIN:    r_cfg.vco_min_khz <= i_cfg_data[VCO_KHZ_W-1:0];
                REG_VCO_MAX:    r_cfg.vco_max_khz <= i_cfg_data[VCO_KHZ_W-1:0];
                REG_MUL_LOW:    r_cfg.mul_low     <= i_cfg_data[MUL_W-1:0];
                REG_MUL_HIGH:   r_cfg.mul_high    <= i_cfg_data[MUL_W-1:0];
                REG_DIV_LOW:    r_cfg.div_low     <= i_cfg_data[DIV_W-1:0];
                REG_DIV_HIGH:   r_cfg.div_high    <= i_cfg_data[DIV_W-1:0];
                REG_SHIFT_HIGH: r_cfg.shift_high  <= i_cfg_data[SHIFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pps_search u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_start     (i_in.valid && w_ready),
        .i_target    (i_in.target_hz),
        .o_ready     (w_ready),
        .o_res_valid (w_res_valid),
        .i_res_take  (w_load),
        .o_res       (w_res)
    );

    assign i_in.ready = w_ready;

    // output register frees the search unit as soon as the word is captured
    assign w_load = w_res_valid && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) r_out <= w_res;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.found         = r_out.found;
    assign o_out.sel_mul       = r_out.sel_mul;
    assign o_out.sel_div       = r_out.sel_div;
    assign o_out.best_shift    = r_out.best_shift;
    assign o_out.best_clock_hz = r_out.best_clock_hz;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// testbench for pll_parameter_search_core: feeds target clock words, predicts each search result
// and checks every result word; depends on pps_pkg, pps_channels and the core

module testbench;
    import pps_pkg::*;

    localparam int unsigned CYCLE_LIMIT       = 2_000_000;
    localparam int unsigned HOLD_CYCLES       = 6000;
    localparam int unsigned RANDOM_SETUPS     = 6;
    localparam int unsigned TARGETS_PER_SETUP = 15;
    localparam int unsigned MAX_GAP           = 12;
    localparam int unsigned DRAIN_CYCLES      = 20;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pps_in_if  req_ch ();
    pps_out_if rsp_ch ();

    pll_parameter_search_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (req_ch),
        .o_out      (rsp_ch)
    );

    t_cfg                pll_cfg;
    logic [TARGET_W-1:0] pending_targets[$];
    t_result             predicted_settings[$];
    t_result             seen_setting;
    t_result             want_setting;
    int unsigned         targets_sent  = 0;
    int unsigned         targets_taken = 0;
    int unsigned         settings_seen = 0;
    int unsigned         mismatches    = 0;
    int unsigned         cycle_count   = 0;
    int unsigned         req_wait      = 0;
    int unsigned         rsp_wait      = 0;
    int unsigned         rsp_gap       = 0;
    int unsigned         hold_left     = 0;
    bit                  hold_req      = 1'b0;
    bit                  hold_done     = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // exhaustive divider / shift / multiplier search, first best candidate kept
    function automatic t_result pll_search(input logic [TARGET_W-1:0] target);
        logic [63:0] ref_hz, lo_vco, hi_vco, vco, out_hz, err, best_err;
        int unsigned d, s, m;
        bit          have;
        t_result     best;
        ref_hz   = 64'(pll_cfg.ref_khz) * KHZ_TO_HZ;
        lo_vco   = 64'(pll_cfg.vco_min_khz) * KHZ_TO_HZ;
        hi_vco   = 64'(pll_cfg.vco_max_khz) * KHZ_TO_HZ;
        best     = '0;
        have     = 1'b0;
        best_err = '0;
        for (d = pll_cfg.div_low; d <= pll_cfg.div_high; d++) begin
            if (d != 0) begin
                for (s = SHIFT_LOW; s <= pll_cfg.shift_high; s++) begin
                    for (m = pll_cfg.mul_low; m <= pll_cfg.mul_high; m++) begin
                        vco    = ref_hz * m / d;
                        out_hz = vco >> s;
                        err    = (out_hz > target) ? out_hz - target : target - out_hz;
                        // vco floor is waived at the largest shift
                        if ((vco >= lo_vco || s == pll_cfg.shift_high) && vco <= hi_vco &&
                            (!have || err < best_err)) begin
                            have               = 1'b1;
                            best_err           = err;
                            best.found         = 1'b1;
                            best.sel_mul       = MUL_W'(m);
                            best.sel_div       = DIV_W'(d);
                            best.best_shift    = SHIFT_W'(s);
                            best.best_clock_hz = CLOCK_W'(out_hz);
                        end
                    end
                end
            end
        end
        return best;
    endfunction

    // a target near a clock from multiplier and divider draws just above their low bounds
    function automatic logic [TARGET_W-1:0] near_target();
        logic [63:0] out_hz;
        longint      t;
        int unsigned m, d;
        m = pll_cfg.mul_low + $urandom_range(0, 15);
        d = pll_cfg.div_low + $urandom_range(0, 3);
        if (d == 0) begin
            d = 1;
        end
        out_hz = (64'(pll_cfg.ref_khz) * KHZ_TO_HZ * m / d) >> $urandom_range(0, pll_cfg.shift_high);
        t = longint'(out_hz) + longint'($urandom_range(0, 2000)) - 1000;
        if (t < 0) begin
            t = 0;
        end else if (t > longint'(32'hFFFF_FFFF)) begin
            t = longint'(32'hFFFF_FFFF);
        end
        return TARGET_W'(t);
    endfunction

    function automatic int unsigned draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_REF_KHZ:    pll_cfg.ref_khz     = REF_W'(data);
            REG_VCO_MIN:    pll_cfg.vco_min_khz = VCO_KHZ_W'(data);
            REG_VCO_MAX:    pll_cfg.vco_max_khz = VCO_KHZ_W'(data);
            REG_MUL_LOW:    pll_cfg.mul_low     = MUL_W'(data);
            REG_MUL_HIGH:   pll_cfg.mul_high    = MUL_W'(data);
            REG_DIV_LOW:    pll_cfg.div_low     = DIV_W'(data);
            REG_DIV_HIGH:   pll_cfg.div_high    = DIV_W'(data);
            REG_SHIFT_HIGH: pll_cfg.shift_high  = SHIFT_W'(data);
            default: ;
        endcase
    endtask

    task automatic set_config(input int unsigned ref_khz, vco_min, vco_max,
                              mul_low, mul_high, div_low, div_high, shift_high);
        write_reg(REG_REF_KHZ, ref_khz);
        write_reg(REG_VCO_MIN, vco_min);
        write_reg(REG_VCO_MAX, vco_max);
        write_reg(REG_MUL_LOW, mul_low);
        write_reg(REG_MUL_HIGH, mul_high);
        write_reg(REG_DIV_LOW, div_low);
        write_reg(REG_DIV_HIGH, div_high);
        write_reg(REG_SHIFT_HIGH, shift_high);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_targets.size() != 0 || req_ch.valid || targets_taken != settings_seen) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic check_field(input string field, input logic [63:0] want, got);
        if (want !== got) begin
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // target word driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_wait     <= 0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (req_wait != 0) begin
                req_ch.valid <= 1'b0;
                req_wait     <= req_wait - 1;
            end else if (pending_targets.size() != 0) begin
                req_ch.valid     <= 1'b1;
                req_ch.target_hz <= pending_targets.pop_front();
                req_wait         <= draw_gap(targets_sent % 32 >= 20);
                targets_sent++;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // predict on every accepted target word
    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            predicted_settings.push_back(pll_search(req_ch.target_hz));
            targets_taken++;
        end
    end

    // result word monitor and ready pacing
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            rsp_wait     <= 0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                seen_setting.found         = rsp_ch.found;
                seen_setting.sel_mul       = rsp_ch.sel_mul;
                seen_setting.sel_div       = rsp_ch.sel_div;
                seen_setting.best_shift    = rsp_ch.best_shift;
                seen_setting.best_clock_hz = rsp_ch.best_clock_hz;
                settings_seen++;
                if (predicted_settings.size() == 0) begin
                    $display("%0t: result word with nothing expected, got %p", $time, seen_setting);
                    mismatches++;
                end else begin
                    want_setting = predicted_settings.pop_front();
                    check_field("found", want_setting.found, seen_setting.found);
                    check_field("sel_mul", want_setting.sel_mul, seen_setting.sel_mul);
                    check_field("sel_div", want_setting.sel_div, seen_setting.sel_div);
                    check_field("best_shift", want_setting.best_shift, seen_setting.best_shift);
                    check_field("best_clock_hz", want_setting.best_clock_hz,
                                seen_setting.best_clock_hz);
                end
            end
            if (hold_req && !hold_done) begin
                // long hold-off so the core backs up and stalls its input
                hold_done    <= 1'b1;
                hold_left    <= HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                rsp_ch.ready <= 1'b0;
            end else if (rsp_wait != 0) begin
                rsp_wait     <= rsp_wait - 1;
                rsp_ch.ready <= 1'b0;
            end else if (rsp_ch.valid && rsp_ch.ready) begin
                rsp_gap = draw_gap(settings_seen % 24 >= 16);
                if (rsp_gap == 0) begin
                    rsp_ch.ready <= 1'b1;
                end else begin
                    rsp_ch.ready <= 1'b0;
                    rsp_wait     <= rsp_gap - 1;
                end
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int unsigned ph, n, rk, vmin, vmax, ml, mh, dl, dh, sh;
        pll_cfg = {RST_REF_KHZ, RST_VCO_MIN, RST_VCO_MAX, RST_MUL_LOW, RST_MUL_HIGH,
                   RST_DIV_LOW, RST_DIV_HIGH, RST_SHIFT_HIGH};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings are slow, so only the two extreme targets
        @(negedge i_clk);
        pending_targets.push_back('0);
        pending_targets.push_back('1);
        wait_idle();

        // largest reference, top of the multiplier and divider range, all shifts
        set_config(262143, 0, 2097151, 1020, 1023, 1020, 1023, 7);
        pending_targets.push_back('0);
        pending_targets.push_back('1);
        pending_targets.push_back(32'h8000_0000);
        pending_targets.push_back(32'h5555_5555);
        pending_targets.push_back(32'hAAAA_AAAA);
        wait_idle();

        // multiplier zero and divider zero, floor waived since the only shift is the largest
        set_config(1, 2097151, 0, 0, 3, 0, 2, 0);
        pending_targets.push_back('0);
        pending_targets.push_back(32'd1000);
        wait_idle();

        // vco ceiling of zero: nothing passes
        set_config(14318, 0, 0, 1, 8, 1, 4, 3);
        pending_targets.push_back(32'd25_175_000);
        wait_idle();

        // empty multiplier range
        set_config(14318, 0, 2097151, 9, 4, 1, 4, 3);
        pending_targets.push_back(32'd40_000_000);
        wait_idle();

        // divider range holding only zero
        set_config(14318, 0, 2097151, 1, 8, 0, 0, 3);
        pending_targets.push_back(32'd1);
        wait_idle();

        // vco window, floor only waived at the largest shift
        set_config(14318, 300000, 600000, 1, 40, 1, 2, 7);
        pending_targets.push_back(32'd5_000_000);
        pending_targets.push_back(32'd25_175_000);
        pending_targets.push_back(32'd100_000_000);
        wait_idle();

        for (ph = 0; ph < RANDOM_SETUPS; ph++) begin
            case ($urandom_range(0, 3))
                0:       rk = 1;
                1:       rk = 262143;
                2:       rk = 14318;
                default: rk = $urandom_range(1, 262143);
            endcase
            vmin = ($urandom_range(0, 2) == 0) ? 0 :
                   ($urandom_range(0, 2097151) >> $urandom_range(0, 8));
            vmax = ($urandom_range(0, 2) == 0) ? 2097151 :
                   vmin + ($urandom_range(0, 2097151) >> $urandom_range(0, 6));
            if (vmax > 2097151) begin
                vmax = 2097151;
            end
            ml = $urandom_range(0, 1023);
            mh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, ml) : ml + $urandom_range(0, 15);
            if (mh > 1023) begin
                mh = 1023;
            end
            dl = $urandom_range(0, 1023);
            dh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, dl) : dl + $urandom_range(0, 3);
            if (dh > 1023) begin
                dh = 1023;
            end
            sh = $urandom_range(0, 7);
            set_config(rk, vmin, vmax, ml, mh, dl, dh, sh);
            for (n = 0; n < TARGETS_PER_SETUP; n++) begin
                if ($urandom_range(0, 1) == 0) begin
                    pending_targets.push_back($urandom);
                end else begin
                    pending_targets.push_back(near_target());
                end
            end
            if (ph == 2) begin
                hold_req = 1'b1;
            end
            wait_idle();
        end

        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && predicted_settings.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ pll_parameter_search_core.f @@
rtl/core/pps_pkg.sv
rtl/core/pps_channels.sv
rtl/core/pps_serial_div.sv
rtl/core/pps_search.sv
rtl/core/pll_parameter_search_core.sv
tb/sv/testbench.sv
